>>> design/rc4_pkg.sv
// Shared types, constants and command/status structs of the RC4 cipher engine.
package rc4_pkg;

    localparam int KEY_DEPTH  = 256;
    localparam int SBOX_DEPTH = 256;
    localparam int SB_AW      = $clog2(SBOX_DEPTH);

    typedef enum logic {
        OP_KEY  = 1'b0,
        OP_DATA = 1'b1
    } op_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] data_byte;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic [7:0] keystream_byte;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_CLR,
        ST_KS_RD_N,
        ST_KS_RD_J,
        ST_KS_WR_N,
        ST_KS_WR_J,
        ST_D_RD_I,
        ST_D_RD_J,
        ST_D_WR_I,
        ST_D_WR_J,
        ST_D_RD_T,
        ST_D_OUT
    } state_t;

    typedef enum logic [1:0] {
        SB_IDLE,
        SB_READ,
        SB_WRITE,
        SB_CLEAR
    } sb_op_t;

    typedef enum logic [2:0] {
        A_I,
        A_I_INC,
        A_J,
        A_J_NEXT,
        A_T
    } addr_sel_t;

    typedef enum logic {
        W_RDATA,
        W_SI
    } wdata_sel_t;

    typedef struct packed {
        sb_op_t     sb_op;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
        logic       key_mix;
        logic       inc_i;
        logic       load_si;
        logic       load_j;
        logic       load_sj;
        logic       load_in;
        logic       key_wr;
        logic       key_rd;
        logic       k_adv;
        logic       clr_idx;
        logic       clr_k;
        logic       clr_kc;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic i_last;
        logic final_flag;
        logic out_free;
    } status_t;

endpackage

>>> design/rc4_ctrl.sv
// Sequencing state machine for key schedule and keystream generation.
module rc4_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  rc4_pkg::op_t      item_op,
    input  logic              item_final,
    output logic              item_ready,
    input  rc4_pkg::status_t  status,
    output rc4_pkg::cmd_t     cmd
);

    rc4_pkg::state_t state_reg;
    rc4_pkg::state_t state_next;
    logic            accept;

    assign item_ready = (state_reg == rc4_pkg::ST_IDLE);
    assign accept     = item_valid && item_ready;

    // Hold state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rc4_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item_op == rc4_pkg::OP_DATA)
                    begin
                        state_next = rc4_pkg::ST_D_RD_I;
                    end
                    else if (item_final)
                    begin
                        state_next = rc4_pkg::ST_KS_CLR;
                    end
                end
            end
            rc4_pkg::ST_KS_CLR:  state_next = rc4_pkg::ST_KS_RD_N;
            rc4_pkg::ST_KS_RD_N: state_next = rc4_pkg::ST_KS_RD_J;
            rc4_pkg::ST_KS_RD_J: state_next = rc4_pkg::ST_KS_WR_N;
            rc4_pkg::ST_KS_WR_N: state_next = rc4_pkg::ST_KS_WR_J;
            rc4_pkg::ST_KS_WR_J:
            begin
                state_next = status.i_last ? rc4_pkg::ST_IDLE : rc4_pkg::ST_KS_RD_N;
            end
            rc4_pkg::ST_D_RD_I:  state_next = rc4_pkg::ST_D_RD_J;
            rc4_pkg::ST_D_RD_J:  state_next = rc4_pkg::ST_D_WR_I;
            rc4_pkg::ST_D_WR_I:  state_next = rc4_pkg::ST_D_WR_J;
            rc4_pkg::ST_D_WR_J:  state_next = rc4_pkg::ST_D_RD_T;
            rc4_pkg::ST_D_RD_T:  state_next = rc4_pkg::ST_D_OUT;
            rc4_pkg::ST_D_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = rc4_pkg::ST_IDLE;
                end
            end
            default: state_next = rc4_pkg::ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.sb_op     = rc4_pkg::SB_IDLE;
        cmd.addr_sel  = rc4_pkg::A_I;
        cmd.wdata_sel = rc4_pkg::W_RDATA;
        unique case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                cmd.load_in = accept;
                cmd.key_wr  = accept && (item_op == rc4_pkg::OP_KEY);
            end
            rc4_pkg::ST_KS_CLR:
            begin
                cmd.sb_op   = rc4_pkg::SB_CLEAR;
                cmd.clr_idx = 1'b1;
                cmd.clr_k   = 1'b1;
            end
            rc4_pkg::ST_KS_RD_N:
            begin
                cmd.sb_op    = rc4_pkg::SB_READ;
                cmd.addr_sel = rc4_pkg::A_I;
                cmd.key_rd   = 1'b1;
            end
            rc4_pkg::ST_KS_RD_J:
            begin
                cmd.sb_op    = rc4_pkg::SB_READ;
                cmd.addr_sel = rc4_pkg::A_J_NEXT;
                cmd.key_mix  = 1'b1;
                cmd.load_si  = 1'b1;
                cmd.load_j   = 1'b1;
            end
            rc4_pkg::ST_KS_WR_N:
            begin
                cmd.sb_op     = rc4_pkg::SB_WRITE;
                cmd.addr_sel  = rc4_pkg::A_I;
                cmd.wdata_sel = rc4_pkg::W_RDATA;
            end
            rc4_pkg::ST_KS_WR_J:
            begin
                cmd.sb_op     = rc4_pkg::SB_WRITE;
                cmd.addr_sel  = rc4_pkg::A_J;
                cmd.wdata_sel = rc4_pkg::W_SI;
                cmd.inc_i     = 1'b1;
                cmd.k_adv     = 1'b1;
                cmd.clr_idx   = status.i_last;
                cmd.clr_kc    = status.i_last;
            end
            rc4_pkg::ST_D_RD_I:
            begin
                cmd.sb_op    = rc4_pkg::SB_READ;
                cmd.addr_sel = rc4_pkg::A_I_INC;
                cmd.inc_i    = 1'b1;
            end
            rc4_pkg::ST_D_RD_J:
            begin
                cmd.sb_op    = rc4_pkg::SB_READ;
                cmd.addr_sel = rc4_pkg::A_J_NEXT;
                cmd.load_si  = 1'b1;
                cmd.load_j   = 1'b1;
            end
            rc4_pkg::ST_D_WR_I:
            begin
                cmd.sb_op     = rc4_pkg::SB_WRITE;
                cmd.addr_sel  = rc4_pkg::A_I;
                cmd.wdata_sel = rc4_pkg::W_RDATA;
                cmd.load_sj   = 1'b1;
            end
            rc4_pkg::ST_D_WR_J:
            begin
                cmd.sb_op     = rc4_pkg::SB_WRITE;
                cmd.addr_sel  = rc4_pkg::A_J;
                cmd.wdata_sel = rc4_pkg::W_SI;
            end
            rc4_pkg::ST_D_RD_T:
            begin
                cmd.sb_op    = rc4_pkg::SB_READ;
                cmd.addr_sel = rc4_pkg::A_T;
            end
            rc4_pkg::ST_D_OUT:
            begin
                cmd.out_load = status.out_free;
                cmd.clr_idx  = status.out_free && status.final_flag;
            end
            default:
            begin
                cmd.sb_op = rc4_pkg::SB_IDLE;
            end
        endcase
    end

endmodule

>>> design/rc4_datapath.sv
// S-box memory, key store, PRGA indices and output register of the RC4 engine.
module rc4_datapath
#(
    parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rc4_pkg::item_t    item,
    input  rc4_pkg::cmd_t     cmd,
    output rc4_pkg::status_t  status,
    output logic              result_valid,
    input  logic              result_ready,
    output rc4_pkg::result_t  result
);

    localparam int KC_W = $clog2(KEY_DEPTH + 1);
    localparam int KA_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int AW   = rc4_pkg::SB_AW;

    // S-box storage with per-entry valid bits; an invalid entry reads as its index
    logic [7:0]                      sbox_mem [rc4_pkg::SBOX_DEPTH];
    logic [rc4_pkg::SBOX_DEPTH-1:0]  valid_reg;
    logic [7:0]                      sb_q_reg;
    logic                            sb_hit_reg;
    logic [AW-1:0]                   sb_qaddr_reg;
    logic [7:0]                      sb_rdata;
    logic [AW-1:0]                   sb_addr;
    logic [7:0]                      sb_wdata;

    // Key store
    logic [7:0]      key_mem [KEY_DEPTH];
    logic [KC_W-1:0] kc_reg;
    logic [KA_W-1:0] k_reg;
    logic [KC_W-1:0] k_inc;
    logic [7:0]      kq_reg;

    // Indices and working bytes
    logic [7:0] i_reg;
    logic [7:0] j_reg;
    logic [7:0] i_inc;
    logic [7:0] j_next;
    logic [7:0] key_term;
    logic [7:0] si_reg;
    logic [7:0] sj_reg;
    logic [7:0] data_reg;
    logic       fin_reg;

    logic             out_valid_reg;
    rc4_pkg::result_t out_reg;

    assign sb_rdata = sb_hit_reg ? sb_q_reg : sb_qaddr_reg;
    assign i_inc    = i_reg + 8'd1;
    assign key_term = cmd.key_mix ? kq_reg : 8'd0;
    assign j_next   = j_reg + sb_rdata + key_term;
    assign k_inc    = KC_W'(k_reg) + KC_W'(1);

    // Select S-box address
    always_comb
    begin
        case (cmd.addr_sel)
            rc4_pkg::A_I:      sb_addr = i_reg;
            rc4_pkg::A_I_INC:  sb_addr = i_inc;
            rc4_pkg::A_J:      sb_addr = j_reg;
            rc4_pkg::A_J_NEXT: sb_addr = j_next;
            rc4_pkg::A_T:      sb_addr = si_reg + sj_reg;
            default:           sb_addr = i_reg;
        endcase
    end

    assign sb_wdata = (cmd.wdata_sel == rc4_pkg::W_SI) ? si_reg : sb_rdata;

    // S-box memory array
    always_ff @(posedge clk)
    begin
        if (cmd.sb_op == rc4_pkg::SB_WRITE)
        begin
            sbox_mem[sb_addr] <= sb_wdata;
        end
        if (cmd.sb_op == rc4_pkg::SB_READ)
        begin
            sb_q_reg     <= sbox_mem[sb_addr];
            sb_hit_reg   <= valid_reg[sb_addr];
            sb_qaddr_reg <= sb_addr;
        end
    end

    // Track written S-box entries; clear all at schedule start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.sb_op == rc4_pkg::SB_CLEAR)
        begin
            valid_reg <= '0;
        end
        else if (cmd.sb_op == rc4_pkg::SB_WRITE)
        begin
            valid_reg[sb_addr] <= 1'b1;
        end
    end

    // Key store memory
    always_ff @(posedge clk)
    begin
        if (cmd.key_wr && (kc_reg < KC_W'(KEY_DEPTH)))
        begin
            key_mem[kc_reg[KA_W-1:0]] <= item.data_byte;
        end
        if (cmd.key_rd)
        begin
            kq_reg <= key_mem[k_reg];
        end
    end

    // Key count and cyclic key index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg <= '0;
            k_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_kc)
            begin
                kc_reg <= '0;
            end
            else if (cmd.key_wr && (kc_reg < KC_W'(KEY_DEPTH)))
            begin
                kc_reg <= kc_reg + KC_W'(1);
            end
            if (cmd.clr_k)
            begin
                k_reg <= '0;
            end
            else if (cmd.k_adv)
            begin
                k_reg <= (k_inc >= kc_reg) ? '0 : k_inc[KA_W-1:0];
            end
        end
    end

    // PRGA indices and final flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg   <= '0;
            j_reg   <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_idx)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            else
            begin
                if (cmd.inc_i)
                begin
                    i_reg <= i_inc;
                end
                if (cmd.load_j)
                begin
                    j_reg <= j_next;
                end
            end
            if (cmd.load_in)
            begin
                fin_reg <= item.final_byte;
            end
        end
    end

    // Capture working bytes
    always_ff @(posedge clk)
    begin
        if (cmd.load_si)
        begin
            si_reg <= sb_rdata;
        end
        if (cmd.load_sj)
        begin
            sj_reg <= sb_rdata;
        end
        if (cmd.load_in)
        begin
            data_reg <= item.data_byte;
        end
        if (cmd.out_load)
        begin
            out_reg.cipher_byte    <= data_reg ^ sb_rdata;
            out_reg.keystream_byte <= sb_rdata;
        end
    end

    // Hold result until the output transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result_valid      = out_valid_reg;
    assign result            = out_reg;
    assign status.i_last     = (i_reg == 8'hFF);
    assign status.final_flag = fin_reg;
    assign status.out_free   = !out_valid_reg || result_ready;

endmodule

>>> design/rc4_stream_cipher.sv
// RC4 stream cipher engine: top level joining controller and datapath.
// A key byte is stored when accepted; a final key byte then keeps the engine busy
// through one S-box clear, then four single-port S-box accesses per step.
// A data byte makes five accesses to the single-port S-box memory, then its result
// is loaded once the output register is free; only then is a new byte accepted.
// Reset clears control state; the S-box reads as identity through per-entry valid bits.
module rc4_stream_cipher
#(
    parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  rc4_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output rc4_pkg::result_t  result
);

    rc4_pkg::cmd_t    cmd;
    rc4_pkg::status_t status;

    rc4_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_op    (item.operation),
        .item_final (item.final_byte),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    rc4_datapath #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTHESIS
    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten");

    // A data transaction keeps the engine busy the next cycle
    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && (item.operation == rc4_pkg::OP_DATA)) |=> !item_ready)
        else $error("engine ready right after data transaction");

    // A result appears only after a load command
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.out_load))
        else $error("result valid without load");

    // No S-box access while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> (cmd.sb_op == rc4_pkg::SB_IDLE))
        else $error("S-box access while idle");
`endif

endmodule
